@@ rtl/core/ipv4_fragment_reassembly_tracker_top_assert.svh @@
// Assertion macros for the IPv4 fragment tracker top level.
// Used by ipv4_fragment_reassembly_tracker_top.sv; no other dependencies.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define IFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define IFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ifrt_pkg.sv @@
// Package for the IPv4 fragment tracker: payload structs, status codes, FSM states.
// No dependencies.
package ifrt_pkg;
	typedef struct packed {
		logic [3:0]  ip_version;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [15:0] flags_offset;
		logic [15:0] ident;
		logic [7:0]  protocol_in;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} hdr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  header_bytes;
		logic [15:0] payload_len;
		logic [15:0] frag_offset_bytes;
		logic [7:0]  ip_protocol;
		logic [3:0]  slot;
		logic [16:0] datagram_len;
	} hdr_out_t;

	localparam logic [2:0] ST_NOT_IPV4  = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_UNFRAG    = 3'd3;
	localparam logic [2:0] ST_PENDING   = 3'd4;
	localparam logic [2:0] ST_COMPLETE  = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	localparam logic [3:0]  IPV4_VERSION = 4'd4;
	localparam int unsigned MF_BIT       = 13;
	localparam logic [16:0] SEEN_MAX     = 17'h1FFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_SCAN,
		S_RMW,
		S_WRITE,
		S_OUT
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic classify;
		logic scan_start;
		logic scan_step;
		logic rmw_read;
		logic write;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_table;
		logic scan_last;
		logic table_full;
	} dp_stat_t;
endpackage

@@ rtl/core/ifrt_ctrl.sv @@
// Controller FSM for the IPv4 fragment tracker.
// Depends on ifrt_pkg.
module ifrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ifrt_pkg::dp_stat_t stat,
	output ifrt_pkg::dp_cmd_t  cmd
);
	import ifrt_pkg::*;

	fsm_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_nx = S_CLASS;
			S_CLASS: state_nx = stat.need_table ? S_SCAN : S_OUT;
			S_SCAN:  if (stat.scan_last) state_nx = S_RMW;
			S_RMW:   state_nx = stat.table_full ? S_OUT : S_WRITE;
			S_WRITE: state_nx = S_OUT;
			S_OUT:   if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_CLASS: begin
				cmd.classify   = 1'b1;
				cmd.scan_start = stat.need_table;
			end
			S_SCAN:  cmd.scan_step = 1'b1;
			S_RMW:   cmd.rmw_read = 1'b1;
			S_WRITE: cmd.write = 1'b1;
			S_OUT:   cmd.emit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/core/ifrt_dp.sv @@
// Datapath for the IPv4 fragment tracker: header classification, entry table, result register.
// Depends on ifrt_pkg.
module ifrt_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ifrt_pkg::hdr_in_t  hdr_in,
	input  ifrt_pkg::dp_cmd_t  cmd,
	output ifrt_pkg::dp_stat_t stat,
	output ifrt_pkg::hdr_out_t hdr_out
);
	import ifrt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// key memories and per-entry counters
	logic [79:0] key_mem [TABLE_ENTRIES];
	logic [33:0] cnt_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	hdr_in_t     hdr_q;
	hdr_out_t    res_q, out_q;
	hdr_out_t    cls_c;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic        hit_q, free_q;
	logic [79:0] key_rd_q;
	logic        key_rd_vld_q;
	logic [IW-1:0] key_rd_idx_q;
	logic [IW-1:0] sel_idx;
	logic        full_c;
	logic [33:0] cnt_rd_q;
	logic        alloc_q;
	logic [16:0] seen_nx, exp_nx;
	logic [17:0] seen_sum;
	logic [5:0]  hb;
	logic        need_table_c;

	assign hb = {hdr_q.header_words, 2'b00};

	// scan index; reads one key per cycle, compared in the next cycle from the registered read
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
		end
		key_rd_q     <= key_mem[idx_q[IW-1:0]];
		key_rd_idx_q <= idx_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_rd_vld_q <= 1'b0;
		end else begin
			key_rd_vld_q <= cmd.scan_step && (idx_q < CW'(TABLE_ENTRIES));
		end
	end

	assign stat.scan_last  = key_rd_vld_q && (key_rd_idx_q == IW'(TABLE_ENTRIES - 1));
	assign stat.need_table = need_table_c;
	assign full_c          = !hit_q && !free_q;
	assign stat.table_full = full_c;
	assign sel_idx         = hit_q ? hit_idx_q : free_idx_q;

	// match and free search over the registered reads
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (key_rd_vld_q) begin
			if (valid_q[key_rd_idx_q]) begin
				if (!hit_q && key_rd_q == {hdr_q.src_addr, hdr_q.dst_addr, hdr_q.ident}) begin
					hit_q     <= 1'b1;
					hit_idx_q <= key_rd_idx_q;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= key_rd_idx_q;
			end
		end
		if (cmd.rmw_read) begin
			cnt_rd_q <= cnt_mem[sel_idx];
			alloc_q  <= !hit_q;
		end
	end

	// header classification of the held transaction
	always_comb begin
		cls_c        = '0;
		need_table_c = 1'b0;
		if (hdr_q.ip_version == IPV4_VERSION) begin
			cls_c.header_bytes = hb;
			cls_c.ip_protocol  = hdr_q.protocol_in;
			if (hdr_q.total_length == 16'd0) begin
				cls_c.status = ST_EMPTY;
			end else if (hdr_q.total_length < {10'd0, hb}) begin
				cls_c.status = ST_MALFORMED;
			end else begin
				cls_c.payload_len = hdr_q.total_length - {10'd0, hb};
				if (hdr_q.flags_offset[13:0] == 14'd0) begin
					cls_c.status = ST_UNFRAG;
				end else begin
					cls_c.frag_offset_bytes = {hdr_q.flags_offset[12:0], 3'b000};
					need_table_c            = 1'b1;
				end
			end
		end else begin
			cls_c.status = ST_NOT_IPV4;
		end
	end

	// seen and expected update
	always_comb begin
		logic [16:0] seen_old, exp_old;
		seen_old = alloc_q ? 17'd0 : cnt_rd_q[33:17];
		exp_old  = alloc_q ? 17'd0 : cnt_rd_q[16:0];
		seen_sum = {1'b0, seen_old} + {2'b00, res_q.payload_len};
		seen_nx  = seen_sum[17] ? SEEN_MAX : seen_sum[16:0];
		exp_nx   = hdr_q.flags_offset[MF_BIT] ? exp_old
		         : ({1'b0, res_q.frag_offset_bytes} + {1'b0, res_q.payload_len});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) hdr_q <= hdr_in;
		if (cmd.classify) res_q <= cls_c;
		if (cmd.rmw_read && full_c) res_q.status <= ST_FULL;
		if (cmd.write) begin
			res_q.slot <= 4'(sel_idx);
			if (seen_nx == exp_nx) begin
				res_q.status       <= ST_COMPLETE;
				res_q.datagram_len <= seen_nx;
			end else begin
				res_q.status <= ST_PENDING;
			end
			cnt_mem[sel_idx] <= {seen_nx, exp_nx};
			if (alloc_q) key_mem[sel_idx] <= {hdr_q.src_addr, hdr_q.dst_addr, hdr_q.ident};
		end
		if (cmd.emit) out_q <= res_q;
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write) begin
			valid_q[sel_idx] <= (seen_nx != exp_nx);
		end
	end

	assign hdr_out = out_q;
endmodule

@@ rtl/core/ipv4_fragment_reassembly_tracker_top.sv @@
// IPv4 fragment reassembly tracker, top level.
// Joins ifrt_ctrl and ifrt_dp; depends on ifrt_pkg and the assertion header.
//
// Input channel hdr_in (valid/stall): decoded fields of one IPv4 header.
// Output channel hdr_out (valid/stall): one result per header: class,
// lengths, table slot and the reassembled length on completion.
// Each header takes its own pass; the next header is accepted only once
// its result is registered. Non-fragment headers go from classification
// straight to the result register. Fragments read the entry table one key
// per cycle, then read the entry's counts and, unless the table is full,
// write them back before the result is registered.
// The result register holds while the receiver stalls; the block may then
// take the next header but keeps the input stalled until the result is taken.
// Reset clears all entries' valid bits at once; the key and count stores
// hold no reset value; their contents are used only for valid entries.
// A matching fragment goes to the lowest valid matching entry, else the
// lowest free entry is claimed; with none free the result is table full.
`include "ipv4_fragment_reassembly_tracker_top_assert.svh"
module ipv4_fragment_reassembly_tracker_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ifrt_pkg::hdr_in_t  hdr_in,
	output logic               out_valid,
	input  logic               out_stall,
	output ifrt_pkg::hdr_out_t hdr_out
);
	import ifrt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ifrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ifrt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr_in  (hdr_in),
		.cmd     (cmd),
		.stat    (stat),
		.hdr_out (hdr_out)
	);

	// a new header is never taken while a transaction is in flight
	`IFR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// table write and result capture never coincide
	`IFR_ASSERT_IMP(a_write_not_emit, clk, arst_n, cmd.write, !cmd.emit)
	// datagram length is zero unless the result is complete
	`IFR_ASSERT_IMP(a_dlen_only_complete, clk, arst_n,
		out_valid && hdr_out.status != ST_COMPLETE, hdr_out.datagram_len == 17'd0)
endmodule

@@ bench/ipv4_fragment_reassembly_tracker_top_test.sv @@
// Self-checking bench for the IPv4 fragment reassembly tracker top level.
// Depends on ifrt_pkg and ipv4_fragment_reassembly_tracker_top.
`timescale 1ns / 100ps
module ipv4_fragment_reassembly_tracker_top_test;
	import ifrt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	hdr_in_t hdr_in;
	logic out_valid;
	logic out_stall;
	hdr_out_t hdr_out;

	ipv4_fragment_reassembly_tracker_top #(.TABLE_ENTRIES(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.hdr_in(hdr_in), .out_valid(out_valid), .out_stall(out_stall), .hdr_out(hdr_out)
	);

	// predicted table of pending datagrams
	logic        tbl_valid [ENTRIES];
	logic [31:0] tbl_src [ENTRIES];
	logic [31:0] tbl_dst [ENTRIES];
	logic [15:0] tbl_ident [ENTRIES];
	logic [16:0] tbl_seen [ENTRIES];
	logic [16:0] tbl_expected [ENTRIES];

	hdr_in_t  header_queue[$];
	hdr_out_t expected_results[$];
	int errors = 0;
	int idle_pct = 28;
	bit sender_done = 0;
	bit hold_req = 0;
	int hold_count = 0;
	int quiet_cycles = 0;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// classify one header and update the predicted table
	function automatic hdr_out_t track_header(hdr_in_t h);
		hdr_out_t r;
		int hit;
		int freei;
		logic [17:0] sum;
		logic [16:0] want;
		r = '0;
		hit = -1;
		freei = -1;
		if (h.ip_version != IPV4_VERSION) begin
			r.status = ST_NOT_IPV4;
			return r;
		end
		r.header_bytes = {h.header_words, 2'b00};
		r.ip_protocol = h.protocol_in;
		if (h.total_length == 0) begin
			r.status = ST_EMPTY;
			return r;
		end
		if (h.total_length < 16'(r.header_bytes)) begin
			r.status = ST_MALFORMED;
			return r;
		end
		r.payload_len = h.total_length - 16'(r.header_bytes);
		if (h.flags_offset[13:0] == 0) begin
			r.status = ST_UNFRAG;
			return r;
		end
		r.frag_offset_bytes = {h.flags_offset[12:0], 3'b000};
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_src[i] == h.src_addr && tbl_dst[i] == h.dst_addr
						&& tbl_ident[i] == h.ident)
					hit = i;
			end else if (freei < 0) begin
				freei = i;
			end
		end
		if (hit < 0) begin
			if (freei < 0) begin
				r.status = ST_FULL;
				return r;
			end
			hit = freei;
			tbl_valid[hit] = 1'b1;
			tbl_src[hit] = h.src_addr;
			tbl_dst[hit] = h.dst_addr;
			tbl_ident[hit] = h.ident;
			tbl_seen[hit] = '0;
			tbl_expected[hit] = '0;
		end
		r.slot = 4'(hit);
		sum = 18'(tbl_seen[hit]) + 18'(r.payload_len);
		tbl_seen[hit] = sum > 18'(SEEN_MAX) ? SEEN_MAX : sum[16:0];
		if (!h.flags_offset[MF_BIT]) begin
			want = 17'(r.frag_offset_bytes) + 17'(r.payload_len);
			tbl_expected[hit] = want;
		end
		if (tbl_seen[hit] == tbl_expected[hit]) begin
			r.status = ST_COMPLETE;
			r.datagram_len = tbl_seen[hit];
			tbl_valid[hit] = 1'b0;
		end else begin
			r.status = ST_PENDING;
		end
		return r;
	endfunction

	function automatic hdr_in_t make_fragment(logic [31:0] s, logic [31:0] d, logic [15:0] id,
			logic [3:0] hw, logic [15:0] tl, logic mf, logic [12:0] off);
		hdr_in_t h;
		h.ip_version = IPV4_VERSION;
		h.header_words = hw;
		h.total_length = tl;
		h.flags_offset = {2'($urandom_range(0, 3)), mf, off};
		h.ident = id;
		h.protocol_in = 8'($urandom);
		h.src_addr = s;
		h.dst_addr = d;
		return h;
	endfunction

	// a well-formed datagram split into n fragments, all queued in order
	task automatic queue_datagram(logic [31:0] s, logic [31:0] d, logic [15:0] id, int n);
		int off;
		int len;
		off = 0;
		for (int k = 0; k < n; k++) begin
			len = 8 * $urandom_range(0, 40);
			header_queue.push_back(make_fragment(s, d, id, 4'd5, 16'(20 + len),
				k != n - 1, 13'(off / 8)));
			off += len;
		end
	endtask

	// stimulus
	initial begin
		hdr_in_t h;
		logic [31:0] s;
		for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
		// directed: each class and the field extremes
		h = make_fragment('1, '1, '1, 4'd15, '1, 1'b0, '0);
		h.ip_version = 4'd6;
		header_queue.push_back(h);
		h.ip_version = 4'd0;
		header_queue.push_back(h);
		header_queue.push_back(make_fragment(32'd1, 32'd2, 16'd3, 4'd5, 16'd0, 1'b1, 13'd1));
		header_queue.push_back(make_fragment(32'd1, 32'd2, 16'd3, 4'd15, 16'd59, 1'b1, 13'd1));
		header_queue.push_back(make_fragment(32'd1, 32'd2, 16'd3, 4'd0, 16'hFFFF, 1'b0, 13'd0));
		h = make_fragment(32'd1, 32'd2, 16'd3, 4'd5, 16'd100, 1'b0, 13'd0);
		h.flags_offset[15:14] = 2'b11;
		header_queue.push_back(h);
		// zero expected: a fragment with no payload completes at once
		header_queue.push_back(make_fragment(32'd7, 32'd8, 16'd9, 4'd5, 16'd20, 1'b1, 13'd0));
		// seen saturates; max offset
		header_queue.push_back(make_fragment(32'd5, 32'd6, 16'd7, 4'd0, 16'hFFFF, 1'b1,
			13'h1FFF));
		header_queue.push_back(make_fragment(32'd5, 32'd6, 16'd7, 4'd0, 16'hFFFF, 1'b1, 13'd0));
		header_queue.push_back(make_fragment(32'd5, 32'd6, 16'd7, 4'd0, 16'hFFFF, 1'b0,
			13'h1FFF));
		// fill the free entries; the last two of these are table full, then complete the filled entries
		for (int i = 0; i < ENTRIES + 1; i++)
			header_queue.push_back(make_fragment(32'hA000_0000 + 32'(i), 32'd0, 16'(i),
				4'd5, 16'd28, 1'b1, 13'd0));
		for (int i = 0; i < ENTRIES; i++)
			header_queue.push_back(make_fragment(32'hA000_0000 + 32'(i), 32'd0, 16'(i),
				4'd5, 16'd28, 1'b0, 13'd1));
		header_queue.push_back(make_fragment(32'd5, 32'd6, 16'd7, 4'd0, 16'd4, 1'b0, 13'd0));
		// random: mostly whole datagrams from a few flows, some noise
		while (header_queue.size() < 1100) begin
			case ($urandom_range(0, 9))
				0: begin
					h = hdr_in_t'({$urandom, $urandom, $urandom, $urandom});
					if ($urandom_range(0, 1)) h.ip_version = IPV4_VERSION;
					header_queue.push_back(h);
				end
				1: begin
					h = make_fragment($urandom, $urandom, 16'($urandom),
						4'($urandom), 16'($urandom_range(0, 80)), 1'($urandom),
						13'($urandom));
					header_queue.push_back(h);
				end
				default: begin
					s = $urandom_range(0, 1) ? 32'($urandom_range(0, 20)) : $urandom;
					queue_datagram(s, $urandom_range(0, 1) ? 32'h0 : $urandom,
						16'($urandom_range(0, 3)), $urandom_range(1, 4));
				end
			endcase
		end
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hdr_in <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(track_header(hdr_in));
				void'(header_queue.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the offered transaction
			end else if (header_queue.size() > ((in_valid && !in_stall) ? 0 : 0)
					&& !(in_valid && !in_stall && header_queue.size() == 0)
					&& $urandom_range(0, 99) >= idle_pct) begin
				in_valid <= 1'b1;
				hdr_in <= header_queue[0];
			end else begin
				in_valid <= 1'b0;
				if (header_queue.size() == 0) sender_done <= 1'b1;
			end
		end
	end

	// idling phases: a stretch with no idling, then a long receiver hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (header_queue.size() == 900) idle_pct <= 0;
			if (header_queue.size() == 600) idle_pct <= 28;
			if (header_queue.size() == 400 && hold_count == 0) hold_req <= 1'b1;
			if (hold_req) begin
				hold_count <= hold_count + 1;
				if (hold_count >= HOLD_CYCLES) hold_req <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		hdr_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, hdr_out);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (hdr_out.status != want.status || hdr_out.header_bytes != want.header_bytes
							|| hdr_out.payload_len != want.payload_len
							|| hdr_out.frag_offset_bytes != want.frag_offset_bytes
							|| hdr_out.ip_protocol != want.ip_protocol
							|| hdr_out.slot != want.slot
							|| hdr_out.datagram_len != want.datagram_len) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, hdr_out);
						errors++;
					end
				end
			end
			out_stall <= hold_req || ($urandom_range(0, 99) < idle_pct);
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_req)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		wait (sender_done && expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ifrt_pkg.sv
rtl/core/ifrt_ctrl.sv
rtl/core/ifrt_dp.sv
rtl/core/ipv4_fragment_reassembly_tracker_top.sv
bench/ipv4_fragment_reassembly_tracker_top_test.sv
